### design/three_plane_intersection_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the three-plane intersection core
// Concurrent checks clocked by clk_i; one form gated by reset, one not.
// ----------------------------------------------------------------------------
`ifndef THREE_PLANE_INTERSECTION_CORE_MACROS_SVH
`define THREE_PLANE_INTERSECTION_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define TPI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tpi check failed");
`define TPI_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("tpi reset check failed");
`else
`define TPI_ASSERT(lbl, prop)
`define TPI_ASSERT_NR(lbl, prop)
`endif

`endif

### design/tpi_pkg.sv
// ----------------------------------------------------------------------------
// tpi_pkg
// Widths, types and helper functions of the three-plane intersection core.
// ----------------------------------------------------------------------------
`default_nettype none

package tpi_pkg;

  localparam int COEFF_W    = 16;
  localparam int COEFF_FRAC = 8;
  localparam int OUT_W      = 32;
  localparam int OUT_FRAC   = OUT_W / 2;
  localparam int TOL_W      = 32;
  localparam int TOL_FRAC   = 24;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(16);

  localparam int DIFF_W  = COEFF_W + 1;
  localparam int MINOR_W = 2 * COEFF_W + 1;
  localparam int PROD_W  = COEFF_W + MINOR_W;
  localparam int DET_W   = PROD_W + 2;
  localparam int MAG_W   = DET_W;
  // tolerance alignment for 2x2 minors and plain coefficient differences
  localparam int TOL_SH2 = TOL_FRAC - 2 * COEFF_FRAC;
  localparam int TOL_SH1 = TOL_FRAC - COEFF_FRAC;
  // integer bits of the result; quotient bits cover them, the fraction bits and one round bit
  localparam int SAT_SH  = OUT_W - 1 - OUT_FRAC;
  localparam int QB      = OUT_W;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_ONE  = 2'd1,
    KIND_INF  = 2'd2
  } kind_e;

  typedef struct packed {
    logic signed [COEFF_W-1:0] a;
    logic signed [COEFF_W-1:0] b;
    logic signed [COEFF_W-1:0] c;
    logic signed [COEFF_W-1:0] d;
  } plane_t;

  typedef struct packed {
    logic signed [DET_W-1:0] dc;
    logic signed [DET_W-1:0] dx;
    logic signed [DET_W-1:0] dy;
    logic signed [DET_W-1:0] dz;
  } det_t;

  typedef struct packed {
    logic minor_hit;  // some 2x2 minor is clear of zero
    logic coinc;      // planes agree coefficient by coefficient
  } cls_t;

  // u*v - w*x, exact
  function automatic logic signed [MINOR_W-1:0] minor2(
    input logic signed [COEFF_W-1:0] u, v, w, x);
    logic signed [MINOR_W-1:0] eu, ev, ew, ex;
    eu = MINOR_W'(u);
    ev = MINOR_W'(v);
    ew = MINOR_W'(w);
    ex = MINOR_W'(x);
    return (eu * ev) - (ew * ex);
  endfunction

  function automatic logic signed [PROD_W-1:0] prod(
    input logic signed [COEFF_W-1:0] u, input logic signed [MINOR_W-1:0] m);
    logic signed [PROD_W-1:0] eu, em;
    eu = PROD_W'(u);
    em = PROD_W'(m);
    return eu * em;
  endfunction

  function automatic logic nz_minor(
    input logic signed [MINOR_W-1:0] m, input logic [TOL_W-1:0] tol);
    logic [MINOR_W-1:0] mg;
    logic [TOL_W-1:0]   t;
    mg = m[MINOR_W-1] ? MINOR_W'(-m) : MINOR_W'(m);
    t  = tol >> TOL_SH2;
    return mg <= MINOR_W'(t);
  endfunction

  function automatic logic nz_diff(
    input logic signed [COEFF_W-1:0] u, v, input logic [TOL_W-1:0] tol);
    logic signed [DIFF_W-1:0] df;
    logic [DIFF_W-1:0]        mg;
    logic [TOL_W-1:0]         t;
    df = DIFF_W'(u) - DIFF_W'(v);
    mg = df[DIFF_W-1] ? DIFF_W'(-df) : DIFF_W'(df);
    t  = tol >> TOL_SH1;
    return {{(TOL_W-DIFF_W){1'b0}}, mg} <= t;
  endfunction

  function automatic logic nz_det(
    input logic signed [DET_W-1:0] v, input logic [TOL_W-1:0] tol);
    logic [MAG_W-1:0] mg;
    mg = v[DET_W-1] ? MAG_W'(-v) : MAG_W'(v);
    return mg <= MAG_W'(tol);
  endfunction

endpackage

`default_nettype wire

### design/tpi_det.sv
// ----------------------------------------------------------------------------
// tpi_det
// Three-stage pipeline forming the four determinants and the class flags.
// ----------------------------------------------------------------------------
`default_nettype none

module tpi_det import tpi_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire plane_t           p_i,
  input  wire plane_t           q_i,
  input  wire plane_t           r_i,
  input  wire logic [TOL_W-1:0] tol_i,
  output logic                  valid_o,
  output det_t                  det_o,
  output cls_t                  cls_o
);

  // stage 1: 2x2 minors, coincidence test
  logic                      v1_q;
  plane_t                    p1_q;
  logic signed [MINOR_W-1:0] m_bc_q, m_ac_q, m_ab_q, m_dc_q, m_db_q, m_ad_q;
  logic signed [MINOR_W-1:0] pq_ab_q, pq_ac_q, pq_bc_q, pr_ab_q, pr_ac_q, pr_bc_q;
  logic                      co1_q, co1_d;

  always_comb begin
    co1_d = nz_diff(p_i.a, q_i.a, tol_i) && nz_diff(p_i.b, q_i.b, tol_i) &&
            nz_diff(p_i.c, q_i.c, tol_i) && nz_diff(p_i.d, q_i.d, tol_i) &&
            nz_diff(p_i.a, r_i.a, tol_i) && nz_diff(p_i.b, r_i.b, tol_i) &&
            nz_diff(p_i.c, r_i.c, tol_i) && nz_diff(p_i.d, r_i.d, tol_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q    <= p_i;
    co1_q   <= co1_d;
    m_bc_q  <= minor2(q_i.b, r_i.c, q_i.c, r_i.b);
    m_ac_q  <= minor2(q_i.a, r_i.c, q_i.c, r_i.a);
    m_ab_q  <= minor2(q_i.a, r_i.b, q_i.b, r_i.a);
    m_dc_q  <= minor2(q_i.d, r_i.c, q_i.c, r_i.d);
    m_db_q  <= minor2(q_i.d, r_i.b, q_i.b, r_i.d);
    m_ad_q  <= minor2(q_i.a, r_i.d, q_i.d, r_i.a);
    pq_ab_q <= minor2(p_i.a, q_i.b, p_i.b, q_i.a);
    pq_ac_q <= minor2(p_i.a, q_i.c, p_i.c, q_i.a);
    pq_bc_q <= minor2(p_i.b, q_i.c, p_i.c, q_i.b);
    pr_ab_q <= minor2(p_i.a, r_i.b, p_i.b, r_i.a);
    pr_ac_q <= minor2(p_i.a, r_i.c, p_i.c, r_i.a);
    pr_bc_q <= minor2(p_i.b, r_i.c, p_i.c, r_i.b);
  end

  // stage 2: cofactor products, minor tests
  logic                     v2_q;
  logic signed [PROD_W-1:0] c0_q, c1_q, c2_q, x0_q, x1_q, x2_q;
  logic signed [PROD_W-1:0] y0_q, y1_q, y2_q, z0_q, z1_q, z2_q;
  cls_t                     cls2_q, cls2_d;

  always_comb begin
    cls2_d.coinc     = co1_q;
    cls2_d.minor_hit = !(nz_minor(pq_ab_q, tol_i) && nz_minor(pq_ac_q, tol_i) &&
                         nz_minor(pq_bc_q, tol_i) && nz_minor(pr_ab_q, tol_i) &&
                         nz_minor(pr_ac_q, tol_i) && nz_minor(pr_bc_q, tol_i) &&
                         nz_minor(m_ab_q, tol_i)  && nz_minor(m_ac_q, tol_i)  &&
                         nz_minor(m_bc_q, tol_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cls2_q <= cls2_d;
    c0_q <= prod(p1_q.a, m_bc_q);
    c1_q <= prod(p1_q.b, m_ac_q);
    c2_q <= prod(p1_q.c, m_ab_q);
    x0_q <= prod(p1_q.b, m_dc_q);
    x1_q <= prod(p1_q.d, m_bc_q);
    x2_q <= prod(p1_q.c, m_db_q);
    y0_q <= prod(p1_q.d, m_ac_q);
    y1_q <= prod(p1_q.a, m_dc_q);
    y2_q <= prod(p1_q.c, m_ad_q);
    z0_q <= prod(p1_q.a, m_db_q);
    z1_q <= prod(p1_q.b, m_ad_q);
    z2_q <= prod(p1_q.d, m_ab_q);
  end

  // stage 3: three-term sums
  logic v3_q;
  det_t det3_q;
  cls_t cls3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cls3_q    <= cls2_q;
    det3_q.dc <= DET_W'(c0_q) - DET_W'(c1_q) + DET_W'(c2_q);
    det3_q.dx <= DET_W'(x0_q) - DET_W'(x1_q) - DET_W'(x2_q);
    det3_q.dy <= DET_W'(y0_q) - DET_W'(y1_q) - DET_W'(y2_q);
    det3_q.dz <= DET_W'(z0_q) + DET_W'(z1_q) - DET_W'(z2_q);
  end

  assign valid_o = v3_q;
  assign det_o   = det3_q;
  assign cls_o   = cls3_q;

endmodule

`default_nettype wire

### design/tpi_div.sv
// ----------------------------------------------------------------------------
// tpi_div
// Pipelined restoring divider: one quotient bit per stage, rounding, clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module tpi_div import tpi_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    valid_i,
  input  wire logic signed [DET_W-1:0] num_i,
  input  wire logic signed [DET_W-1:0] den_i,
  input  wire kind_e                   tag_i,
  output logic                         valid_o,
  output logic [OUT_W-1:0]             value_o,
  output logic                         sat_o,
  output kind_e                        tag_o
);

  // stage A: magnitudes and sign
  logic             va_q, nega_q;
  logic [MAG_W-1:0] na_q, da_q;
  kind_e            taga_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    na_q   <= num_i[DET_W-1] ? MAG_W'(-num_i) : MAG_W'(num_i);
    da_q   <= den_i[DET_W-1] ? MAG_W'(-den_i) : MAG_W'(den_i);
    nega_q <= num_i[DET_W-1] ^ den_i[DET_W-1];
    taga_q <= tag_i;
  end

  // stage 0 of the iteration: overflow check and initial remainder
  logic             v_q   [0:QB];
  logic [MAG_W-1:0] r_q   [0:QB];
  logic [MAG_W-1:0] d_q   [0:QB];
  logic [OUT_W-1:0] nl_q  [0:QB];
  logic [OUT_W-1:0] qt_q  [0:QB];
  logic             neg_q [0:QB];
  logic             ov_q  [0:QB];
  logic             top_q [0:QB];
  kind_e            tag_q [0:QB];

  logic [MAG_W+SAT_SH-1:0] n_ext, d_sh;
  logic                    big, top, presat;

  // a negative quotient with integer part exactly at the range end still
  // reaches the bottom of the range; only a nonzero rounded fraction clamps
  assign n_ext  = {{SAT_SH{1'b0}}, na_q};
  assign d_sh   = {da_q, {SAT_SH{1'b0}}};
  assign big    = n_ext >= d_sh;
  assign top    = nega_q && big && (n_ext < (d_sh + {{SAT_SH{1'b0}}, da_q}));
  assign presat = big && !top;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // an overflowing or zero divisor is replaced; the result is clamped anyway
    d_q[0]   <= presat ? MAG_W'(1) : da_q;
    r_q[0]   <= presat ? '0 : (top ? ((na_q >> SAT_SH) - da_q) : (na_q >> SAT_SH));
    nl_q[0]  <= {na_q[SAT_SH-1:0], {(OUT_FRAC+1){1'b0}}};
    qt_q[0]  <= '0;
    neg_q[0] <= nega_q;
    ov_q[0]  <= presat;
    top_q[0] <= top;
    tag_q[0] <= taga_q;
  end

  for (genvar k = 1; k <= QB; k++) begin : g_bit
    logic [MAG_W:0]   t;
    logic             ge;
    logic [MAG_W-1:0] rn;

    always_comb begin
      t  = {r_q[k-1], nl_q[k-1][OUT_W-1]};
      ge = t >= {1'b0, d_q[k-1]};
      rn = ge ? MAG_W'(t - {1'b0, d_q[k-1]}) : t[MAG_W-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      r_q[k]   <= rn;
      d_q[k]   <= d_q[k-1];
      nl_q[k]  <= {nl_q[k-1][OUT_W-2:0], 1'b0};
      qt_q[k]  <= {qt_q[k-1][OUT_W-2:0], ge};
      neg_q[k] <= neg_q[k-1];
      ov_q[k]  <= ov_q[k-1];
      top_q[k] <= top_q[k-1];
      tag_q[k] <= tag_q[k-1];
    end
  end

  // final stage: round half away from zero, clamp, apply sign
  logic [OUT_W:0]   sum;
  logic [OUT_W-1:0] m, lim, mm;
  logic             over;

  always_comb begin
    sum  = {1'b0, qt_q[QB]} + (OUT_W+1)'(1);
    // add back the integer part taken off ahead of the iteration
    m    = top_q[QB] ? {1'b1, sum[OUT_W-1:1]} : sum[OUT_W:1];
    lim  = neg_q[QB] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    over = ov_q[QB] || (m > lim);
    mm   = over ? lim : m;
  end

  logic             vf_q, satf_q;
  logic [OUT_W-1:0] valf_q;
  kind_e            tagf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else begin
      vf_q <= v_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    valf_q <= neg_q[QB] ? OUT_W'(-mm) : mm;
    satf_q <= over;
    tagf_q <= tag_q[QB];
  end

  assign valid_o = vf_q;
  assign value_o = valf_q;
  assign sat_o   = satf_q;
  assign tag_o   = tagf_q;

endmodule

`default_nettype wire

### design/three_plane_intersection_core.sv
// ----------------------------------------------------------------------------
// three_plane_intersection_core
// Intersection of three planes by Cramer's rule, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the twelve Q8.8 coefficients and pulse start_i; a transaction is
//   taken at every rising edge with start_i high and busy_o low. busy_o is
//   never raised, so one transaction can enter every cycle.
//   done_o is high for exactly one cycle per result, which passes through
//   40 register stages in all: three stages build the determinants, one
//   classifies, and the divider pipeline spends one stage per quotient bit
//   (32 bits) plus magnitude, range check and rounding stages, then the
//   output register. Results leave in the order the transactions came in.
//   The receiver cannot stall; it must take each result in its done_o cycle.
//   Write zero_tolerance_i with zero_tolerance_we_i only while no transaction
//   is in flight. Reset clears every valid bit and sets the tolerance to 16.
//   kind_o: 0 none, 1 single point, 2 infinite; point and saturated_o are
//   zero unless kind_o is 1.
// ----------------------------------------------------------------------------
`default_nettype none

`include "three_plane_intersection_core_macros.svh"

module three_plane_intersection_core import tpi_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  output logic                           busy_o,
  input  wire logic signed [COEFF_W-1:0] first_a_i,
  input  wire logic signed [COEFF_W-1:0] first_b_i,
  input  wire logic signed [COEFF_W-1:0] first_c_i,
  input  wire logic signed [COEFF_W-1:0] first_d_i,
  input  wire logic signed [COEFF_W-1:0] second_a_i,
  input  wire logic signed [COEFF_W-1:0] second_b_i,
  input  wire logic signed [COEFF_W-1:0] second_c_i,
  input  wire logic signed [COEFF_W-1:0] second_d_i,
  input  wire logic signed [COEFF_W-1:0] third_a_i,
  input  wire logic signed [COEFF_W-1:0] third_b_i,
  input  wire logic signed [COEFF_W-1:0] third_c_i,
  input  wire logic signed [COEFF_W-1:0] third_d_i,
  input  wire logic                      zero_tolerance_we_i,
  input  wire logic [TOL_W-1:0]          zero_tolerance_i,
  output logic                           done_o,
  output logic signed [OUT_W-1:0]        point_x_o,
  output logic signed [OUT_W-1:0]        point_y_o,
  output logic signed [OUT_W-1:0]        point_z_o,
  output logic [1:0]                     kind_o,
  output logic                           saturated_o
);

  logic [TOL_W-1:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (zero_tolerance_we_i) begin
      tol_q <= zero_tolerance_i;
    end
  end

  assign busy_o = 1'b0;

  plane_t p, q, r;
  assign p = '{a: first_a_i,  b: first_b_i,  c: first_c_i,  d: first_d_i};
  assign q = '{a: second_a_i, b: second_b_i, c: second_c_i, d: second_d_i};
  assign r = '{a: third_a_i,  b: third_b_i,  c: third_c_i,  d: third_d_i};

  logic det_v;
  det_t det;
  cls_t cls;

  tpi_det u_det (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .p_i     (p),
    .q_i     (q),
    .r_i     (r),
    .tol_i   (tol_q),
    .valid_o (det_v),
    .det_o   (det),
    .cls_o   (cls)
  );

  // classify
  kind_e kind_d, kind_q;
  logic  cv_q;
  det_t  det_q;

  always_comb begin
    priority if (!nz_det(det.dc, tol_q)) begin
      kind_d = KIND_ONE;
    end else if (nz_det(det.dx, tol_q) && nz_det(det.dy, tol_q) &&
                 nz_det(det.dz, tol_q) && (cls.minor_hit || cls.coinc)) begin
      kind_d = KIND_INF;
    end else begin
      kind_d = KIND_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= 1'b0;
    end else begin
      cv_q <= det_v;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    det_q  <= det;
  end

  logic             vx, vy, vz, sx, sy, sz;
  logic [OUT_W-1:0] qx, qy, qz;
  kind_e            kx, ky, kz;

  tpi_div u_div_x (
    .clk_i, .rst_ni, .valid_i (cv_q), .num_i (det_q.dx), .den_i (det_q.dc),
    .tag_i (kind_q), .valid_o (vx), .value_o (qx), .sat_o (sx), .tag_o (kx)
  );

  tpi_div u_div_y (
    .clk_i, .rst_ni, .valid_i (cv_q), .num_i (det_q.dy), .den_i (det_q.dc),
    .tag_i (kind_q), .valid_o (vy), .value_o (qy), .sat_o (sy), .tag_o (ky)
  );

  tpi_div u_div_z (
    .clk_i, .rst_ni, .valid_i (cv_q), .num_i (det_q.dz), .den_i (det_q.dc),
    .tag_i (kind_q), .valid_o (vz), .value_o (qz), .sat_o (sz), .tag_o (kz)
  );

  // output register; zero the point unless a single point was found
  logic             done_q, sat_q;
  logic [OUT_W-1:0] px_q, py_q, pz_q;
  kind_e            ko_q;
  logic             one;

  assign one = (kx == KIND_ONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vx;
    end
  end

  always_ff @(posedge clk_i) begin
    ko_q  <= kx;
    px_q  <= one ? qx : '0;
    py_q  <= one ? qy : '0;
    pz_q  <= one ? qz : '0;
    sat_q <= one && (sx || sy || sz);
  end

  assign done_o      = done_q;
  assign point_x_o   = px_q;
  assign point_y_o   = py_q;
  assign point_z_o   = pz_q;
  assign kind_o      = ko_q;
  assign saturated_o = sat_q;

  `TPI_ASSERT(a_lanes_aligned, vx |-> (vy && vz && (ky == kx) && (kz == kx)))
  `TPI_ASSERT(a_point_zero_off_one, (done_o && kind_o != KIND_ONE) |->
    (point_x_o == '0 && point_y_o == '0 && point_z_o == '0 && !saturated_o))
  `TPI_ASSERT(a_done_follows_div, done_o == $past(vx))
  `TPI_ASSERT_NR(a_quiet_in_reset, !rst_ni |=> (!done_o && !vx && !cv_q))

endmodule

`default_nettype wire
